// ----- rtl/dnld_pkg.sv -----
package dnld_pkg;

    localparam int NAME_BUFFER_SIZE_DEF = 200;
    localparam int QUEUE_DEPTH          = 4;
    localparam logic [7:0] DOT_CHAR     = 8'h2E;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_LABEL = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_DONE    = 2'd1,
        ST_OVERRUN = 2'd2
    } t_status;

    // command from the classifier to the emitter
    typedef struct packed {
        logic       clear;    // new name: reset the character count
        logic       emit;     // a result item follows from this command
        logic       counted;  // character subject to the name limit
        logic [7:0] ch;
        t_status    status;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/dnld_in_if.sv -----
interface dnld_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic [15:0] payload_length;

    modport source (output valid, payload_byte, first_byte, payload_length, input ready);
    modport sink   (input valid, payload_byte, first_byte, payload_length, output ready);
endinterface

// ----- rtl/dnld_out_if.sv -----
interface dnld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       char_valid;
    logic [1:0] status;
    logic       last;

    modport source (output valid, name_char, char_valid, status, last, input ready);
    modport sink   (input valid, name_char, char_valid, status, last, output ready);
endinterface

// ----- rtl/dnld_front.sv -----
module dnld_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dnld_in_if.sink         i_in,
    input  dnld_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output dnld_pkg::t_cmd  o_cmd
);

    dnld_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_bytes_left, n_bytes_left;
    logic [7:0]       r_label_left, n_label_left;

    logic        w_accept;
    logic [15:0] w_first_left;
    logic [15:0] w_dec_left;
    logic [7:0]  w_label_dec;
    logic [16:0] w_len_plus1;

    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_first_left = i_in.payload_length - 16'd1;
    assign w_dec_left   = (r_bytes_left != 16'd0) ? r_bytes_left - 16'd1 : 16'd0;
    assign w_label_dec  = (r_label_left != 8'd0) ? r_label_left - 8'd1 : 8'd0;
    // label plus the length byte after it, without wrap
    assign w_len_plus1  = {9'd0, i_in.payload_byte} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dnld_pkg::PH_IDLE;
            r_bytes_left <= 16'd0;
            r_label_left <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_label_left <= n_label_left;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_label_left = r_label_left;
        o_push       = 1'b0;
        o_cmd        = '{clear: 1'b0, emit: 1'b0, counted: 1'b0, ch: 8'd0,
                         status: dnld_pkg::ST_BUSY, last: 1'b0};
        if (w_accept) begin
            if (i_in.first_byte) begin
                o_push       = 1'b1;
                o_cmd.clear  = 1'b1;
                n_label_left = 8'd0;
                n_phase      = dnld_pkg::PH_IDLE;
                if (i_in.payload_length == 16'd0) begin
                    n_bytes_left = 16'd0;
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = dnld_pkg::ST_OVERRUN;
                    o_cmd.last   = 1'b1;
                end else begin
                    n_bytes_left = w_first_left;
                    if (i_in.payload_byte == 8'd0) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = dnld_pkg::ST_DONE;
                        o_cmd.last   = 1'b1;
                    end else if (w_len_plus1 > {1'b0, w_first_left}) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = dnld_pkg::ST_OVERRUN;
                        o_cmd.last   = 1'b1;
                    end else begin
                        n_label_left = i_in.payload_byte;
                        n_phase      = dnld_pkg::PH_LABEL;
                    end
                end
            end else begin
                unique case (r_phase)
                    dnld_pkg::PH_LABEL: begin
                        n_bytes_left  = w_dec_left;
                        n_label_left  = w_label_dec;
                        if (w_label_dec == 8'd0) begin
                            n_phase = dnld_pkg::PH_LEN;
                        end
                        o_push        = 1'b1;
                        o_cmd.emit    = 1'b1;
                        o_cmd.counted = 1'b1;
                        o_cmd.ch      = i_in.payload_byte;
                    end
                    dnld_pkg::PH_LEN: begin
                        n_bytes_left = w_dec_left;
                        o_push       = 1'b1;
                        o_cmd.emit   = 1'b1;
                        if (i_in.payload_byte == 8'd0) begin
                            n_phase       = dnld_pkg::PH_IDLE;
                            o_cmd.counted = 1'b1;
                            o_cmd.ch      = dnld_pkg::DOT_CHAR;
                            o_cmd.status  = dnld_pkg::ST_DONE;
                            o_cmd.last    = 1'b1;
                        end else if (w_len_plus1 > {1'b0, w_dec_left}) begin
                            n_phase      = dnld_pkg::PH_IDLE;
                            o_cmd.status = dnld_pkg::ST_OVERRUN;
                            o_cmd.last   = 1'b1;
                        end else begin
                            n_label_left  = i_in.payload_byte;
                            n_phase       = dnld_pkg::PH_LABEL;
                            o_cmd.counted = 1'b1;
                            o_cmd.ch      = dnld_pkg::DOT_CHAR;
                        end
                    end
                    default: begin
                        // idle or unused code: byte ignored
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/dnld_fifo.sv -----
module dnld_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dnld_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output dnld_pkg::t_cmd    o_head,
    output dnld_pkg::t_q_stat o_stat
);

    localparam int DEPTH = dnld_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    dnld_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           w_do_push, w_do_pop;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/dnld_back.sv -----
module dnld_back #(
    parameter int NAME_BUFFER_SIZE = dnld_pkg::NAME_BUFFER_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dnld_pkg::t_cmd    i_head,
    input  dnld_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    dnld_out_if.source        o_out
);

    localparam int CW = $clog2(NAME_BUFFER_SIZE);
    localparam logic [CW-1:0] CHAR_LIMIT = CW'(NAME_BUFFER_SIZE - 1);

    logic [CW-1:0] r_chars, n_chars;
    logic          r_valid, n_valid;
    logic [7:0]    r_char, n_char;
    logic          r_char_valid, n_char_valid;
    logic [1:0]    r_status, n_status;
    logic          r_last, n_last;
    logic [CW-1:0] w_base;

    // commands that give no result never wait on the output register
    assign o_pop = !i_q_stat.empty
                   && (!i_head.emit || !r_valid || o_out.ready);
    assign w_base = i_head.clear ? '0 : r_chars;

    assign o_out.valid      = r_valid;
    assign o_out.name_char  = r_char;
    assign o_out.char_valid = r_char_valid;
    assign o_out.status     = r_status;
    assign o_out.last       = r_last;

    always_comb begin
        n_chars      = r_chars;
        n_valid      = r_valid;
        n_char       = r_char;
        n_char_valid = r_char_valid;
        n_status     = r_status;
        n_last       = r_last;
        if (r_valid && o_out.ready) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_chars = w_base;
            if (i_head.emit) begin
                n_valid      = 1'b1;
                n_status     = i_head.status;
                n_last       = i_head.last;
                n_char       = 8'd0;
                n_char_valid = 1'b0;
                if (i_head.counted && (w_base < CHAR_LIMIT)) begin
                    n_chars      = w_base + CW'(1);
                    n_char       = i_head.ch;
                    n_char_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= '0;
            r_valid <= 1'b0;
        end else begin
            r_chars <= n_chars;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_char_valid <= n_char_valid;
        r_status     <= n_status;
        r_last       <= n_last;
    end

endmodule

// ----- rtl/dns_name_label_decoder_unit.sv -----
// dns name label decoder: one payload byte accepted per cycle while the command queue has room
// a result passes through the command queue and then the output register
// throughput: one item per cycle while the result side takes items, set by the classifier
// update and the emitter popping the four-entry command queue once per cycle
// reset: synchronous, active low; clears phase, counters, queue and output valid
module dns_name_label_decoder_unit #(
    parameter int NAME_BUFFER_SIZE = dnld_pkg::NAME_BUFFER_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnld_in_if.sink     i_in,
    dnld_out_if.source  o_out
);

    dnld_pkg::t_cmd    w_push_cmd;
    dnld_pkg::t_cmd    w_head;
    dnld_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    dnld_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    dnld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    dnld_back #(
        .NAME_BUFFER_SIZE (NAME_BUFFER_SIZE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_queue_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue both full and empty");

    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> w_q_stat.full)
        else $error("input stalled with room in the queue");

    a_dropped_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.char_valid) |-> (o_out.name_char == 8'd0))
        else $error("dropped item carries a character");

    a_busy_not_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == dnld_pkg::ST_BUSY)) |-> !o_out.last)
        else $error("in-progress item marked last");

    a_push_after_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head.emit) |=> o_out.valid)
        else $error("emitted command left no result");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_LIMIT    = dnld_pkg::NAME_BUFFER_SIZE_DEF - 1;
    localparam int ITEM_TARGET   = 1830;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        PLEN_EXACT,
        PLEN_SLACK,
        PLEN_SHORT
    } t_plen_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       kept;
        logic [1:0] status;
        logic       last;
    } t_name_result;

    class name_decode_scoreboard;
        dnld_pkg::t_phase phase;
        logic [15:0]      bytes_left;
        logic [7:0]       label_left;
        logic [7:0]       chars_kept;
        t_name_result     expected_chars[$];
        int               errors;

        function new();
            phase      = dnld_pkg::PH_IDLE;
            bytes_left = '0;
            label_left = '0;
            chars_kept = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function t_name_result name_end(logic [1:0] st);
            t_name_result r;
            r.ch     = 8'h00;
            r.kept   = 1'b0;
            r.status = st;
            r.last   = 1'b1;
            return r;
        endfunction

        // characters past the name limit come out as dropped
        function t_name_result keep_char(logic [7:0] ch, logic [1:0] st, logic lst);
            t_name_result r;
            r.status = st;
            r.last   = lst;
            if (chars_kept < NAME_LIMIT) begin
                chars_kept++;
                r.ch   = ch;
                r.kept = 1'b1;
            end else begin
                r.ch   = 8'h00;
                r.kept = 1'b0;
            end
            return r;
        endfunction

        // the label and the length byte after it must fit, no wrap
        function bit label_overruns(logic [7:0] len);
            return (int'(len) + 1) > int'(bytes_left);
        endfunction

        function void note_byte(logic [7:0] b, logic first, logic [15:0] plen);
            t_name_result r;
            bit           produced;
            produced = 1'b0;
            if (first) begin
                chars_kept = '0;
                label_left = '0;
                phase      = dnld_pkg::PH_IDLE;
                if (plen == 16'd0) begin
                    bytes_left = '0;
                    r = name_end(dnld_pkg::ST_OVERRUN);
                    produced = 1'b1;
                end else begin
                    bytes_left = plen - 16'd1;
                    if (b == 8'h00) begin
                        r = name_end(dnld_pkg::ST_DONE);
                        produced = 1'b1;
                    end else if (label_overruns(b)) begin
                        r = name_end(dnld_pkg::ST_OVERRUN);
                        produced = 1'b1;
                    end else begin
                        label_left = b;
                        phase      = dnld_pkg::PH_LABEL;
                    end
                end
            end else if (phase == dnld_pkg::PH_LABEL) begin
                if (bytes_left != 16'd0) bytes_left--;
                if (label_left != 8'd0) label_left--;
                if (label_left == 8'd0) phase = dnld_pkg::PH_LEN;
                r = keep_char(b, dnld_pkg::ST_BUSY, 1'b0);
                produced = 1'b1;
            end else if (phase == dnld_pkg::PH_LEN) begin
                if (bytes_left != 16'd0) bytes_left--;
                if (b == 8'h00) begin
                    phase = dnld_pkg::PH_IDLE;
                    r = keep_char(dnld_pkg::DOT_CHAR, dnld_pkg::ST_DONE, 1'b1);
                end else if (label_overruns(b)) begin
                    phase = dnld_pkg::PH_IDLE;
                    r = name_end(dnld_pkg::ST_OVERRUN);
                end else begin
                    label_left = b;
                    phase      = dnld_pkg::PH_LABEL;
                    r = keep_char(dnld_pkg::DOT_CHAR, dnld_pkg::ST_BUSY, 1'b0);
                end
                produced = 1'b1;
            end
            if (produced) expected_chars.push_back(r);
        endfunction

        function void check_result(t_name_result got);
            t_name_result want;
            if (expected_chars.size() == 0) begin
                errors++;
                $display("%0t: no result expected, got char %02h kept %0b status %0d last %0b",
                         $time, got.ch, got.kept, got.status, got.last);
                return;
            end
            want = expected_chars.pop_front();
            if (got.ch !== want.ch) begin
                errors++;
                $display("%0t: name_char expected %02h got %02h", $time, want.ch, got.ch);
            end
            if (got.kept !== want.kept) begin
                errors++;
                $display("%0t: char_valid expected %0b got %0b", $time, want.kept, got.kept);
            end
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dnld_in_if  in_if();
    dnld_out_if out_if();

    dns_name_label_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    name_decode_scoreboard sb;
    t_name_result          seen;
    int                    items_sent;
    int                    quiet_cycles;
    bit                    no_gaps;
    bit                    hold_req;
    bit                    hold_active;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sampling and checking of both channels, plus the stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_byte(in_if.payload_byte, in_if.first_byte, in_if.payload_length);
            if (out_if.valid && out_if.ready) begin
                seen.ch     = out_if.name_char;
                seen.kept   = out_if.char_valid;
                seen.status = out_if.status;
                seen.last   = out_if.last;
                sb.check_result(seen);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // result side: random stalls, calm stretches and one long hold-off on request
    initial begin
        int stall_left;
        bit calm;
        stall_left = 0;
        calm = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_active = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                out_if.ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 149) == 0) calm = !calm;
                if (stall_left > 0) begin
                    stall_left--;
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] plen);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.payload_byte   <= b;
        in_if.first_byte     <= first;
        in_if.payload_length <= plen;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
    endtask

    // sender stops offering until every expected result is out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_name(input int n_labels, input int min_len, input int max_len,
                             input bit longest_first, input t_plen_mode plen_mode,
                             input bit cut_short);
        logic [7:0] wire_q[$];
        int         len;
        int         total;
        int         plen;
        int         n_send;
        for (int i = 0; i < n_labels; i++) begin
            len = (longest_first && i == 0) ? 255 : $urandom_range(min_len, max_len);
            wire_q.push_back(8'(len));
            repeat (len) wire_q.push_back(8'($urandom_range(0, 255)));
        end
        wire_q.push_back(8'h00);
        total = wire_q.size();
        case (plen_mode)
            PLEN_SHORT: plen = $urandom_range(1, total - 1);
            PLEN_SLACK: begin
                if ($urandom_range(0, 1) == 0)
                    plen = total + $urandom_range(1, 8);
                else
                    plen = $urandom_range(total + 1, 65535);
            end
            default:    plen = total;
        endcase
        n_send = cut_short ? $urandom_range(1, total - 1) : total;
        for (int i = 0; i < n_send; i++)
            send_byte(wire_q[i], i == 0, (i == 0) ? 16'(plen) : 16'($urandom_range(0, 65535)));
        // trailing bytes after the end are ignored
        if (!cut_short)
            repeat ($urandom_range(0, 2))
                send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
    endtask

    initial begin
        int         pick;
        int         long_sent;
        t_plen_mode mode;
        sb = new();
        items_sent   = 0;
        quiet_cycles = 0;
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        hold_active  = 1'b0;
        long_sent    = 0;
        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.payload_byte   <= 8'h00;
        in_if.first_byte     <= 1'b0;
        in_if.payload_length <= 16'h0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty name
        send_byte(8'h00, 1'b1, 16'd1);
        // byte while idle
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        // longest label in the longest payload, then a restart inside it
        send_byte(8'hFF, 1'b1, 16'hFFFF);
        send_byte(8'h41, 1'b0, 16'h0000);
        // one byte left after the first length byte
        send_byte(8'h01, 1'b1, 16'd2);
        // first label longer than the payload
        send_byte(8'h05, 1'b1, 16'd1);
        // 0xff and 0x00 as label bytes, exact fit
        send_byte(8'h01, 1'b1, 16'd5);
        send_byte(8'hFF, 1'b0, 16'd0);
        send_byte(8'h01, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0, 16'd0);
        send_byte(8'h03, 1'b0, 16'h8000);
        // second label overruns
        send_byte(8'h01, 1'b1, 16'd4);
        send_byte(8'h61, 1'b0, 16'd0);
        send_byte(8'h05, 1'b0, 16'd0);
        // second label with only one byte left
        send_byte(8'h01, 1'b1, 16'd4);
        send_byte(8'h62, 1'b0, 16'd0);
        send_byte(8'h01, 1'b0, 16'd0);
        // a dot inside a label
        send_byte(8'h01, 1'b1, 16'd3);
        send_byte(8'h2E, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0, 16'd0);
        // restart part way through a label
        send_byte(8'h03, 1'b1, 16'd100);
        send_byte(8'h78, 1'b0, 16'd0);
        send_byte(8'h00, 1'b1, 16'h8000);
        wait_drained();

        // back-to-back name while the result side is held off
        hold_req = 1'b1;
        while (!hold_active) @(posedge i_clk);
        no_gaps = 1'b1;
        send_name(4, 8, 12, 1'b0, PLEN_EXACT, 1'b0);
        no_gaps = 1'b0;
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (long_sent < 2 && items_sent > 500 * (long_sent + 1)) begin
                // long enough to run past the name limit
                mode = ($urandom_range(0, 1) == 0) ? PLEN_EXACT : PLEN_SLACK;
                send_name(3, 70, 130, long_sent == 0, mode, 1'b0);
                long_sent++;
            end else if (pick < 65) begin
                mode = ($urandom_range(0, 1) == 0) ? PLEN_EXACT : PLEN_SLACK;
                send_name($urandom_range(1, 5), 1, 12, 1'b0, mode, 1'b0);
            end else if (pick < 77) begin
                send_name($urandom_range(1, 4), 1, 12, 1'b0, PLEN_SHORT, 1'b0);
            end else if (pick < 87) begin
                send_name($urandom_range(1, 4), 1, 12, 1'b0, PLEN_EXACT, 1'b1);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                              16'($urandom_range(1, 65535)));
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            if (sb.pending() != 0)
                $display("%0t: %0d expected results never arrived", $time, sb.pending());
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
